/* rtl/first_fit_allocator_with_coalescing_unit_macros.svh */
// Assertion helpers shared by the allocator modules.
// Each expects clk and arst_n in scope.
`ifndef FIRST_FIT_ALLOCATOR_WITH_COALESCING_UNIT_MACROS_SVH
`define FIRST_FIT_ALLOCATOR_WITH_COALESCING_UNIT_MACROS_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ffa_pkg.sv */
package ffa_pkg;

	localparam int SIZE_W   = 16;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 2;
	localparam int PDATA_W  = 32;

	localparam logic [SIZE_W-1:0] POOL_RESET = 16'd1000;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FLUSH,
		S_DONE
	} ffa_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic flush;
		logic load;
	} ffa_cmd_t;

	typedef struct packed {
		logic scan_done;
	} ffa_sts_t;

endpackage

/* rtl/first_fit_allocator_with_coalescing_unit.sv */
// Channel   Direction  Handshake             Word
// in        input      in_valid / in_ready   func, req_size, free_address
// out       output     out_valid / out_ready granted_address, status
// cfg       input      APB (psel, penable)   pool_size at every paddr, read back on prdata
//
// One request at a time: after an accept, the free-list scan reads the list through
// the single read port of the list RAM, one entry per cycle, then a flush/commit
// step and the result hand-off follow before the next accept.
// The list is kept in two RAM banks; each request streams the current bank into
// the other and flips banks only if the request succeeds, so failures leave the
// list untouched.
// Reset: no clearing pass. After reset or a pool_size write, the single block
// {0, pool_size} (none for a zero pool) is supplied from the register, not the RAM.
// Stalls: the result sits in an output register; the next word is accepted
// while it waits, and a later result holds in the done state until the slot drains.

module first_fit_allocator_with_coalescing_unit import ffa_pkg::*; #(
	parameter int MAX_BLOCKS = 16,
	parameter int ADDR_BITS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 func,
	input  logic [SIZE_W-1:0]    req_size,
	input  logic [SIZE_W-1:0]    free_address,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [SIZE_W-1:0]    granted_address,
	output logic [STATUS_W-1:0]  status,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready
);

	localparam int RAW = $clog2(MAX_BLOCKS) + 1;
	localparam int EW  = 2 * ADDR_BITS;

	ffa_cmd_t          cmd;
	ffa_sts_t          sts;
	logic              cfg_we;
	logic [SIZE_W-1:0] pool_size;
	logic              ram_we, ram_re;
	logic [RAW-1:0]    ram_waddr, ram_raddr;
	logic [EW-1:0]     ram_wdata, ram_rdata;

	// single register: every address in the window decodes to pool_size
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready && (paddr[PADDR_W-1:0] == '0 ||
		paddr[PADDR_W-1:0] != '0);
	assign prdata = {{(PDATA_W - SIZE_W){1'b0}}, pool_size};

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_dp #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.req_size        (req_size),
		.free_address    (free_address),
		.cfg_we          (cfg_we),
		.cfg_wdata       (pwdata[SIZE_W-1:0]),
		.pool_size       (pool_size),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.ram_re          (ram_re),
		.ram_raddr       (ram_raddr),
		.ram_rdata       (ram_rdata),
		.granted_address (granted_address),
		.status          (status)
	);

	// two banks of start/length pairs, bank select in the address MSB
	ffa_ram #(
		.WIDTH (EW),
		.DEPTH (1 << RAW)
	) u_list_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

/* rtl/ffa_ram.sv */
module ffa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/ffa_ctrl.sv */
`include "first_fit_allocator_with_coalescing_unit_macros.svh"

module ffa_ctrl import ffa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ffa_sts_t sts,
	output ffa_cmd_t cmd
);

	ffa_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`FFA_ASSERT_NEXT(a_accept_scan, in_valid && in_ready, state_q == S_SCAN,
		"accepted word did not start a scan")
	`FFA_ASSERT_NOW(a_no_overwrite, cmd.load, !out_valid_q || out_ready,
		"pending result overwritten")
	`FFA_ASSERT_NOW(a_cmd_onehot, 1'b1,
		$onehot0({cmd.start, cmd.scan, cmd.flush, cmd.load}),
		"more than one datapath command")

endmodule

/* rtl/ffa_dp.sv */
`include "first_fit_allocator_with_coalescing_unit_macros.svh"

module ffa_dp import ffa_pkg::*; #(
	parameter int MAX_BLOCKS = 16,
	parameter int ADDR_BITS  = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ffa_cmd_t                              cmd,
	output ffa_sts_t                              sts,
	input  logic                                  func,
	input  logic [SIZE_W-1:0]                     req_size,
	input  logic [SIZE_W-1:0]                     free_address,
	input  logic                                  cfg_we,
	input  logic [SIZE_W-1:0]                     cfg_wdata,
	output logic [SIZE_W-1:0]                     pool_size,
	output logic                                  ram_we,
	output logic [$clog2(MAX_BLOCKS):0]           ram_waddr,
	output logic [2*ADDR_BITS-1:0]                ram_wdata,
	output logic                                  ram_re,
	output logic [$clog2(MAX_BLOCKS):0]           ram_raddr,
	input  logic [2*ADDR_BITS-1:0]                ram_rdata,
	output logic [SIZE_W-1:0]                     granted_address,
	output logic [STATUS_W-1:0]                   status
);

	localparam int AW = ADDR_BITS;
	localparam int EW = 2 * ADDR_BITS;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int WW = $clog2(MAX_BLOCKS + 2);

	// list state
	logic              bank_q;
	logic              fresh_q;   // list is the single restart block, held in pool_q
	logic [SIZE_W-1:0] pool_q;
	logic [CW-1:0]     cnt_q;

	// scan control
	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [WW-1:0] wr_idx_q;
	logic          found_q, brk_q, dly_q;

	// operand and result payload
	logic                func_q;
	logic [AW-1:0]       size_q, lo_q, hi_q, gnt_q;
	logic [EW-1:0]       carry_q;
	logic [SIZE_W-1:0]   res_gnt_q, out_gnt_q;
	logic [STATUS_W-1:0] res_sts_q, out_sts_q;

	logic [EW-1:0] ent, mrg_ent, wr_ent;
	logic [AW-1:0] st, ln, ent_end, mrg_len;
	logic          issue, wr_en, set_found, set_brk, set_dly, ld_carry, ld_hi, ld_lo;
	logic [WW-1:0] fin_cnt;
	logic          ok, commit;

	assign ent     = fresh_q ? {{AW{1'b0}}, AW'(pool_q)} : ram_rdata;
	assign st      = ent[EW-1:AW];
	assign ln      = ent[AW-1:0];
	assign ent_end = st + ln;
	assign mrg_len = hi_q - lo_q;
	assign mrg_ent = {lo_q, mrg_len};

	assign issue         = cmd.scan && (rd_idx_q < cnt_q);
	assign sts.scan_done = (rd_idx_q == cnt_q) && !vld_s1;

	always_comb begin
		wr_en     = 1'b0;
		wr_ent    = ent;
		set_found = 1'b0;
		set_brk   = 1'b0;
		set_dly   = 1'b0;
		ld_carry  = 1'b0;
		ld_hi     = 1'b0;
		ld_lo     = 1'b0;
		if (cmd.scan && vld_s1) begin
			if (func_q == FUNC_ALLOC) begin
				if (!found_q && (ln >= size_q)) begin
					// carve from the front; a used-up block is dropped
					set_found = 1'b1;
					wr_ent    = {st + size_q, ln - size_q};
					wr_en     = (ln != size_q);
				end else begin
					wr_en = 1'b1;
				end
			end else begin
				priority if (brk_q) begin
					// past the insert point: stream runs one entry behind, via carry_q, when a block went in
					wr_en    = 1'b1;
					wr_ent   = dly_q ? carry_q : ent;
					ld_carry = dly_q;
				end else if (st > hi_q) begin
					set_brk = 1'b1;
					wr_en   = 1'b1;
					if (mrg_len != '0) begin
						wr_ent   = mrg_ent;
						set_dly  = 1'b1;
						ld_carry = 1'b1;
					end
				end else if (st == hi_q) begin
					ld_hi = 1'b1;
				end else if (ent_end == lo_q) begin
					ld_lo = 1'b1;
				end else begin
					wr_en = 1'b1;
				end
			end
		end else if (cmd.flush && (func_q == FUNC_FREE)) begin
			if (brk_q) begin
				wr_en  = dly_q;
				wr_ent = carry_q;
			end else begin
				wr_en  = (mrg_len != '0);
				wr_ent = mrg_ent;
			end
		end
	end

	assign fin_cnt = wr_idx_q + WW'(wr_en);
	assign ok      = (func_q == FUNC_ALLOC) ? found_q : (fin_cnt <= WW'(MAX_BLOCKS));
	assign commit  = cmd.flush && ok;

	// new list goes into the other bank; the bank flips only on commit
	assign ram_we    = wr_en && (wr_idx_q < WW'(MAX_BLOCKS));
	assign ram_waddr = {~bank_q, wr_idx_q[IW-1:0]};
	assign ram_wdata = wr_ent;
	assign ram_re    = issue;
	assign ram_raddr = {bank_q, rd_idx_q[IW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q   <= 1'b0;
			fresh_q  <= 1'b1;
			pool_q   <= POOL_RESET;
			cnt_q    <= CW'(AW'(POOL_RESET) != {AW{1'b0}});
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			wr_idx_q <= '0;
			found_q  <= 1'b0;
			brk_q    <= 1'b0;
			dly_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_q  <= cfg_wdata;
				fresh_q <= 1'b1;
				cnt_q   <= CW'(AW'(cfg_wdata) != {AW{1'b0}});
			end else if (commit) begin
				bank_q  <= ~bank_q;
				fresh_q <= 1'b0;
				cnt_q   <= fin_cnt[CW-1:0];
			end
			if (cmd.start) begin
				rd_idx_q <= '0;
				vld_s1   <= 1'b0;
				wr_idx_q <= '0;
				found_q  <= 1'b0;
				brk_q    <= 1'b0;
				dly_q    <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (wr_en) begin
					wr_idx_q <= fin_cnt;
				end
				if (set_found) begin
					found_q <= 1'b1;
				end
				if (set_brk) begin
					brk_q <= 1'b1;
					dly_q <= set_dly;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			func_q <= func;
			size_q <= AW'(req_size);
			lo_q   <= AW'(free_address);
			hi_q   <= AW'(free_address) + AW'(req_size);
		end else begin
			if (ld_hi) begin
				hi_q <= hi_q + ln;
			end
			if (ld_lo) begin
				lo_q <= st;
			end
		end
		if (set_found) begin
			gnt_q <= st;
		end
		if (ld_carry) begin
			carry_q <= ent;
		end
		if (cmd.flush) begin
			if (func_q == FUNC_ALLOC) begin
				res_gnt_q <= found_q ? SIZE_W'(gnt_q) : '0;
				res_sts_q <= found_q ? ST_OK : ST_NOFIT;
			end else begin
				res_gnt_q <= '0;
				res_sts_q <= ok ? ST_OK : ST_FULL;
			end
		end
		if (cmd.load) begin
			out_gnt_q <= res_gnt_q;
			out_sts_q <= res_sts_q;
		end
	end

	assign pool_size       = pool_q;
	assign granted_address = out_gnt_q;
	assign status          = out_sts_q;

	`FFA_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q <= CW'(MAX_BLOCKS),
		"block count beyond capacity")
	`FFA_ASSERT_NOW(a_fresh_cnt, fresh_q, cnt_q <= CW'(1),
		"restart list holds more than one block")
	`FFA_ASSERT_NOW(a_wr_le_rd, cmd.scan && sts.scan_done, wr_idx_q <= WW'(rd_idx_q),
		"scan wrote more entries than it read")

endmodule

/* tb/ffa_checker.sv */
`timescale 1ns / 1ps

module ffa_checker import ffa_pkg::*; #(
	parameter int                 MAX_BLOCKS = 16,
	parameter logic [PADDR_W-1:0] POOL_ADDR  = '0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic                func,
	input  logic [SIZE_W-1:0]   req_size,
	input  logic [SIZE_W-1:0]   free_address,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [SIZE_W-1:0]   granted_address,
	input  logic [STATUS_W-1:0] status,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic [PDATA_W-1:0]  prdata,
	output int                  fail_count,
	output int                  pending
);

	typedef struct packed {
		logic [SIZE_W-1:0]   addr;
		logic [STATUS_W-1:0] code;
	} grant_t;

	grant_t            grant_q[$];
	logic [SIZE_W-1:0] pool_q;
	logic [SIZE_W-1:0] fl_start [MAX_BLOCKS];
	logic [SIZE_W-1:0] fl_len   [MAX_BLOCKS];
	int                fl_cnt;
	int                word_idx;

	// one block {0, pool}, or nothing for a zero pool
	function automatic void restart_list();
		for (int k = 0; k < MAX_BLOCKS; k++) begin
			fl_start[k] = '0;
			fl_len[k]   = '0;
		end
		fl_len[0] = pool_q;
		fl_cnt    = (pool_q != '0) ? 1 : 0;
	endfunction

	// first fit, carved from the front; an emptied block leaves the list
	function automatic grant_t carve_front(input logic [SIZE_W-1:0] size);
		grant_t r;
		logic   hit;
		r.addr = '0;
		r.code = ST_NOFIT;
		hit    = 1'b0;
		for (int k = 0; k < fl_cnt && !hit; k++) begin
			if (fl_len[k] >= size) begin
				hit         = 1'b1;
				r.addr      = fl_start[k];
				r.code      = ST_OK;
				fl_start[k] = fl_start[k] + size;
				fl_len[k]   = fl_len[k] - size;
				if (fl_len[k] == '0) begin
					for (int j = k; j + 1 < fl_cnt; j++) begin
						fl_start[j] = fl_start[j + 1];
						fl_len[j]   = fl_len[j + 1];
					end
					fl_cnt--;
				end
			end
		end
		return r;
	endfunction

	// coalesce with neighbors on a scratch copy, commit only on success
	function automatic logic [STATUS_W-1:0] return_region(input logic [SIZE_W-1:0] addr,
			input logic [SIZE_W-1:0] size);
		logic [SIZE_W-1:0] st [MAX_BLOCKS];
		logic [SIZE_W-1:0] ln [MAX_BLOCKS];
		logic [SIZE_W-1:0] lo, hi, tail, span;
		int                cnt, pos;
		logic              stop, drop;
		st   = fl_start;
		ln   = fl_len;
		cnt  = fl_cnt;
		lo   = addr;
		hi   = addr + size;
		pos  = 0;
		stop = 1'b0;
		while (pos < cnt && !stop) begin
			tail = st[pos] + ln[pos];
			drop = 1'b0;
			if (st[pos] > hi)
				stop = 1'b1;
			else if (st[pos] == hi) begin
				hi   = hi + ln[pos];
				drop = 1'b1;
			end else if (tail == lo) begin
				lo   = st[pos];
				drop = 1'b1;
			end else
				pos++;
			if (drop) begin
				for (int k = pos; k + 1 < cnt; k++) begin
					st[k] = st[k + 1];
					ln[k] = ln[k + 1];
				end
				cnt--;
			end
		end
		span = hi - lo;
		if (span != '0) begin
			if (cnt >= MAX_BLOCKS)
				return ST_FULL;
			for (int k = cnt; k > pos; k--) begin
				st[k] = st[k - 1];
				ln[k] = ln[k - 1];
			end
			st[pos] = lo;
			ln[pos] = span;
			cnt++;
		end
		fl_start = st;
		fl_len   = ln;
		fl_cnt   = cnt;
		return ST_OK;
	endfunction

	task automatic flag(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		grant_t want;
		grant_t made;
		if (!arst_n) begin
			pool_q = POOL_RESET;
			restart_list();
			grant_q.delete();
			word_idx = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (grant_q.size() == 0)
					flag($sformatf("result %0d: unexpected word addr %h status %0d",
						word_idx, granted_address, status));
				else begin
					want = grant_q.pop_front();
					if (granted_address !== want.addr)
						flag($sformatf("result %0d: granted_address expected %h got %h",
							word_idx, want.addr, granted_address));
					if (status !== want.code)
						flag($sformatf("result %0d: status expected %0d got %0d",
							word_idx, want.code, status));
				end
				word_idx++;
			end
			if (in_valid && in_ready) begin
				if (func == FUNC_ALLOC)
					made = carve_front(req_size);
				else begin
					made.addr = '0;
					made.code = return_region(free_address, req_size);
				end
				grant_q.push_back(made);
			end
			if (psel && penable && pready && paddr == POOL_ADDR) begin
				if (pwrite) begin
					pool_q = pwdata[SIZE_W-1:0];
					restart_list();
				end else if (prdata[SIZE_W-1:0] !== pool_q)
					flag($sformatf("pool_size readback expected %h got %h",
						pool_q, prdata[SIZE_W-1:0]));
			end
			pending <= grant_q.size();
		end
	end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

// Stimulus and verdict for the first-fit allocator. The checker beside the
// block predicts every result word; this module only drives the channels.
module testbench import ffa_pkg::*;;

	localparam int                 MAX_BLOCKS = 16;
	localparam logic [PADDR_W-1:0] POOL_ADDR  = '0;
	localparam int                 PHASE_LEN  = 180;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic [SIZE_W-1:0]   req_size;
	logic [SIZE_W-1:0]   free_address;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SIZE_W-1:0]   granted_address;
	logic [STATUS_W-1:0] status;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int fail_count;
	int pending;

	// calm: no idling on either side
	logic calm = 1'b0;

	// what was sent, in order, so granted words can be paired with their size
	typedef struct packed {
		logic              f;
		logic [SIZE_W-1:0] size;
	} sent_t;

	// a region that is currently allocated and may be handed back
	typedef struct packed {
		logic [SIZE_W-1:0] addr;
		logic [SIZE_W-1:0] size;
	} region_t;

	sent_t   sent_q[$];
	region_t live_q[$];
	int      pool_cur;

	always #5 clk = ~clk;

	first_fit_allocator_with_coalescing_unit #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.ADDR_BITS (SIZE_W)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.req_size       (req_size),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_address(granted_address),
		.status         (status),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	ffa_checker #(
		.MAX_BLOCKS(MAX_BLOCKS),
		.POOL_ADDR (POOL_ADDR)
	) u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.req_size       (req_size),
		.free_address   (free_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.granted_address(granted_address),
		.status         (status),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	// receiver back-pressure: out_ready low with a chance of about 18 percent
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= 18);
	end

	// Granted words feed the pool of live regions that later frees return.
	// Captured at the edge, consumed at the falling edge, so the stimulus
	// process never races the update.
	logic              took_res = 1'b0;
	logic [SIZE_W-1:0] took_grant;
	logic [STATUS_W-1:0] took_code;

	always @(posedge clk) begin
		took_res   <= out_valid && out_ready;
		took_grant <= granted_address;
		took_code  <= status;
	end

	always @(negedge clk) begin
		sent_t   item;
		region_t fresh;
		if (took_res && sent_q.size() != 0) begin
			item = sent_q.pop_front();
			if (item.f == FUNC_ALLOC && took_code == ST_OK && item.size != '0) begin
				fresh.addr = took_grant;
				fresh.size = item.size;
				live_q.push_back(fresh);
			end
		end
	end

	// random sender gaps: short bursts of idle, now and then a long one
	task automatic pause();
		int n;
		if (calm)
			return;
		n = 0;
		while ($urandom_range(99) < 18)
			n++;
		if ($urandom_range(99) < 3)
			n += $urandom_range(40, 2);
		repeat (n) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// valid stays up after acceptance; the caller lowers it when it idles
	task automatic send_word(input logic f, input logic [SIZE_W-1:0] s,
			input logic [SIZE_W-1:0] a);
		sent_t item;
		in_valid     <= 1'b1;
		func         <= f;
		req_size     <= s;
		free_address <= a;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		item.f    = f;
		item.size = s;
		sent_q.push_back(item);
	endtask

	// wait until every word sent has come back
	task automatic quiesce();
		int n;
		n = 0;
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while ((pending != 0 || sent_q.size() != 0) && n < 200000);
	endtask

	// setup phase, access phase held until pready, then an idle bus phase
	task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// new pool: only while idle; junk in the upper bits must not matter
	task automatic set_pool(input logic [SIZE_W-1:0] v);
		logic [31:0] junk;
		quiesce();
		junk = $urandom;
		apb_xfer(1'b1, POOL_ADDR, {junk[31:16], v});
		apb_xfer(1'b0, POOL_ADDR, '0);
		pool_cur = int'(v);
		live_q.delete();
	endtask

	// Mostly well-formed traffic: allocations sized to the pool and frees
	// that return live regions, whole or front part. The rest is noise.
	task automatic random_item();
		int                r, mx, idx;
		logic [SIZE_W-1:0] s, a;
		region_t           slot;
		r = $urandom_range(99);
		pause();
		if (r >= 50 && r < 88 && live_q.size() != 0) begin
			idx  = $urandom_range(live_q.size() - 1, 0);
			slot = live_q[idx];
			if ($urandom_range(1) == 1)
				s = slot.size;
			else
				s = SIZE_W'($urandom_range(slot.size, 1));
			a = slot.addr;
			if (s == slot.size)
				live_q.delete(idx);
			else begin
				slot.addr = slot.addr + s;
				slot.size = slot.size - s;
				live_q[idx] = slot;
			end
			send_word(FUNC_FREE, s, a);
		end else if (r >= 88) begin
			// arbitrary frees: overlaps, double frees, wrap past the top
			if ($urandom_range(1) == 1) begin
				a = SIZE_W'($urandom_range(pool_cur, 0));
				s = SIZE_W'($urandom_range(64, 0));
			end else begin
				a = SIZE_W'($urandom);
				s = SIZE_W'($urandom);
			end
			send_word(FUNC_FREE, s, a);
		end else begin
			mx = pool_cur / 8;
			if (mx < 1)
				mx = 1;
			r = $urandom_range(99);
			if (r < 5)
				s = '0;
			else if (r < 10)
				s = SIZE_W'($urandom);
			else
				s = SIZE_W'($urandom_range(mx, 1));
			send_word(FUNC_ALLOC, s, SIZE_W'($urandom));
		end
	endtask

	initial begin
		int pools [8];
		in_valid     <= 1'b0;
		func         <= FUNC_ALLOC;
		req_size     <= '0;
		free_address <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		arst_n       <= 1'b0;
		pool_cur = int'(POOL_RESET);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of pool_size
		apb_xfer(1'b0, POOL_ADDR, '0);

		// directed: zero-size grant, no fit, block used up, empty list,
		// empty merge, merge with next, with previous, at the head, wrap
		send_word(FUNC_ALLOC, 16'd0, 16'd0);
		send_word(FUNC_ALLOC, 16'hFFFF, 16'hFFFF);
		send_word(FUNC_ALLOC, 16'd1000, 16'd0);
		send_word(FUNC_ALLOC, 16'd0, 16'd0);
		send_word(FUNC_FREE, 16'd0, 16'd0);
		send_word(FUNC_FREE, 16'd100, 16'd500);
		send_word(FUNC_FREE, 16'd100, 16'd400);
		send_word(FUNC_FREE, 16'd50, 16'd600);
		send_word(FUNC_FREE, 16'd400, 16'd0);
		send_word(FUNC_FREE, 16'd2, 16'hFFFF);

		// empty pool, then isolated frees until the list overflows
		set_pool(16'd0);
		for (int i = 0; i <= MAX_BLOCKS; i++)
			send_word(FUNC_FREE, 16'd4, 16'(i * 8));

		pools = '{1000, 65535, 1, 64, 0, 0, 0, 300};
		pools[5] = $urandom_range(65534, 2);
		pools[6] = $urandom_range(200, 1);
		for (int ph = 0; ph < 8; ph++) begin
			set_pool(16'(pools[ph]));
			calm <= (ph == 3);
			repeat (PHASE_LEN) random_item();
		end
		calm <= 1'b0;

		quiesce();
		// let any trailing activity show before the verdict
		repeat (4 * (MAX_BLOCKS + 5)) @(posedge clk);
		if (fail_count == 0 && pending == 0 && sent_q.size() == 0)
			$display("first_fit_allocator_with_coalescing_unit test passed");
		else
			$display("first_fit_allocator_with_coalescing_unit test failed");
		$finish;
	end

	// hung handshake guard
	initial begin
		#(10_000_000);
		$display("first_fit_allocator_with_coalescing_unit test failed");
		$finish;
	end

endmodule
